// File: src/keyed_span_extractor_assert.svh
// Assertion macros shared by the keyed span extractor modules.
// Each use expects signals clk and rst_n in the enclosing module.
`ifndef KEYED_SPAN_EXTRACTOR_ASSERT_SVH
`define KEYED_SPAN_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KSE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed_span_extractor assertion failed");

// Next-cycle implication, checked outside reset.
`define KSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed_span_extractor assertion failed");

`endif

// File: src/kse_pkg.sv
// Package for the keyed span extractor: keywords, codes, queue entry type.
// No dependencies.
package kse_pkg;

  localparam logic [55:0] KEY_BIDS  = 56'h2262696473223a;
  localparam logic [55:0] KEY_ASKS  = 56'h2261736b73223a;
  localparam logic [55:0] KEY_STAMP = 56'h7374616d70223a;

  localparam logic [7:0] CH_OPEN  = 8'h5b;
  localparam logic [7:0] CH_CLOSE = 8'h5d;
  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0]  DEPTH_MAX  = 8'd255;
  localparam logic [15:0] OFFSET_MAX = 16'hffff;

  localparam logic [1:0] MODE_SCAN   = 2'd0;
  localparam logic [1:0] MODE_ARRAY  = 2'd1;
  localparam logic [1:0] MODE_SKIP   = 2'd2;
  localparam logic [1:0] MODE_DIGITS = 2'd3;

  localparam logic [1:0] KIND_BIDS  = 2'd0;
  localparam logic [1:0] KIND_ASKS  = 2'd1;
  localparam logic [1:0] KIND_STAMP = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic        has_span;
    logic [1:0]  span_kind;
    logic [15:0] span_start;
    logic [15:0] span_length;
    logic        has_end;
    logic        end_status;
  } event_t;

endpackage

// File: src/kse_front.sv
// Front end: accepts message bytes, matches keywords, tracks spans.
// Emits one queue entry per byte that yields results. Uses kse_pkg.
module kse_front
  import kse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       q_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       q_wr,
  output event_t     q_entry
);

  logic [55:0] window_r, window_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        asks_r, asks_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic        stopped_r, stopped_nxt;
  logic        accept;
  logic        ended;

  assign accept = push && !q_full;

  always_comb begin
    window_nxt  = window_r;
    mode_nxt    = mode_r;
    asks_nxt    = asks_r;
    depth_nxt   = depth_r;
    offset_nxt  = offset_r;
    cap_nxt     = cap_r;
    stopped_nxt = stopped_r;
    ended       = 1'b0;
    q_entry     = '0;
    if (accept) begin
      if (stopped_r) begin
        if (in_last_byte) begin
          stopped_nxt = 1'b0;
        end
      end else begin
        if (in_data_byte != CH_NUL) begin
          case (mode_r)
            MODE_SCAN: begin
              window_nxt = {window_r[47:0], in_data_byte};
              if (window_nxt == KEY_BIDS) begin
                mode_nxt  = MODE_ARRAY;
                asks_nxt  = 1'b0;
                depth_nxt = '0;
              end else if (window_nxt == KEY_ASKS) begin
                mode_nxt  = MODE_ARRAY;
                asks_nxt  = 1'b1;
                depth_nxt = '0;
              end else if (window_nxt == KEY_STAMP) begin
                mode_nxt = MODE_SKIP;
              end
            end
            MODE_ARRAY: begin
              if (in_data_byte == CH_OPEN) begin
                if (depth_r == '0) begin
                  cap_nxt = offset_r;
                end
                if (depth_r != DEPTH_MAX) begin
                  depth_nxt = depth_r + 8'd1;
                end
              end else if (in_data_byte == CH_CLOSE && depth_r != '0) begin
                depth_nxt = depth_r - 8'd1;
                if (depth_r == 8'd1) begin
                  q_entry.has_span    = 1'b1;
                  q_entry.span_kind   = asks_r ? KIND_ASKS : KIND_BIDS;
                  q_entry.span_start  = cap_r;
                  q_entry.span_length = offset_r - cap_r + 16'd1;
                  mode_nxt            = MODE_SCAN;
                end
              end
            end
            MODE_SKIP: begin
              if (in_data_byte inside {[DIGIT_LO:DIGIT_HI]}) begin
                cap_nxt  = offset_r;
                mode_nxt = MODE_DIGITS;
              end
            end
            MODE_DIGITS: begin
              if (!(in_data_byte inside {[DIGIT_LO:DIGIT_HI]})) begin
                q_entry.has_span    = 1'b1;
                q_entry.span_kind   = KIND_STAMP;
                q_entry.span_start  = cap_r;
                q_entry.span_length = offset_r - cap_r;
                mode_nxt            = MODE_SCAN;
              end
            end
            default: begin
              mode_nxt = MODE_SCAN;
            end
          endcase
          if (offset_r != OFFSET_MAX) begin
            offset_nxt = offset_r + 16'd1;
          end
        end
        ended = (in_data_byte == CH_NUL) || in_last_byte;
        if (ended) begin
          if (mode_nxt == MODE_DIGITS) begin
            q_entry.has_span    = 1'b1;
            q_entry.span_kind   = KIND_STAMP;
            q_entry.span_start  = cap_nxt;
            q_entry.span_length = offset_nxt - cap_nxt;
          end
          q_entry.has_end    = 1'b1;
          q_entry.end_status = (mode_nxt == MODE_ARRAY);
          stopped_nxt        = !in_last_byte;
        end
      end
      if (ended || (stopped_r && in_last_byte)) begin
        window_nxt = '0;
        mode_nxt   = MODE_SCAN;
        asks_nxt   = 1'b0;
        depth_nxt  = '0;
        offset_nxt = '0;
        cap_nxt    = '0;
      end
    end
  end

  assign q_wr = accept && (q_entry.has_span || q_entry.has_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      mode_r    <= MODE_SCAN;
      asks_r    <= 1'b0;
      depth_r   <= '0;
      offset_r  <= '0;
      cap_r     <= '0;
      stopped_r <= 1'b0;
    end else begin
      window_r  <= window_nxt;
      mode_r    <= mode_nxt;
      asks_r    <= asks_nxt;
      depth_r   <= depth_nxt;
      offset_r  <= offset_nxt;
      cap_r     <= cap_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// File: src/kse_queue.sv
// Small event queue between front and back end.
// Uses kse_pkg and the assertion macros.
`include "keyed_span_extractor_assert.svh"
module kse_queue
  import kse_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr,
  input  event_t wr_entry,
  input  logic   rd,
  output event_t head,
  output logic   empty,
  output logic   full
);

  event_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `KSE_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= (QAW+1)'(QDEPTH))
  `KSE_ASSERT_IMPL(a_no_overflow, wr, !full)
  `KSE_ASSERT_NEXT(a_grow, rst_n && do_wr && !do_rd, cnt_r == $past(cnt_r) + 1'b1)

endmodule

// File: src/kse_back.sv
// Back end: splits queue entries into result items behind an output register.
// Uses kse_pkg and the assertion macros.
`include "keyed_span_extractor_assert.svh"
module kse_back
  import kse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  event_t      q_head,
  input  logic        q_empty,
  output logic        q_rd,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_field_kind,
  output logic [15:0] out_span_start,
  output logic [15:0] out_span_length,
  output logic        out_status,
  output logic        out_end_of_run
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] start_r, start_nxt;
  logic [15:0] len_r, len_nxt;
  logic        status_r, status_nxt;
  logic        eor_r, eor_nxt;
  logic        load;
  logic        emit_span;

  assign load      = !q_empty && (!valid_r || pop);
  assign emit_span = q_head.has_span && !phase_r;

  always_comb begin
    valid_nxt  = valid_r && !pop;
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    status_nxt = status_r;
    eor_nxt    = eor_r;
    q_rd       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (emit_span) begin
        kind_nxt   = q_head.span_kind;
        start_nxt  = q_head.span_start;
        len_nxt    = q_head.span_length;
        status_nxt = 1'b0;
        eor_nxt    = !q_head.has_end;
      end else begin
        kind_nxt   = KIND_END;
        start_nxt  = '0;
        len_nxt    = '0;
        status_nxt = q_head.end_status;
        eor_nxt    = 1'b1;
      end
      if (emit_span && q_head.has_end) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        q_rd      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    start_r  <= start_nxt;
    len_r    <= len_nxt;
    status_r <= status_nxt;
    eor_r    <= eor_nxt;
  end

  assign empty           = !valid_r;
  assign out_field_kind  = kind_r;
  assign out_span_start  = start_r;
  assign out_span_length = len_r;
  assign out_status      = status_r;
  assign out_end_of_run  = eor_r;

  `KSE_ASSERT_IMPL(a_phase_head, phase_r, !q_empty)
  `KSE_ASSERT_IMPL(a_head_nonnull, !q_empty, q_head.has_span || q_head.has_end)
  `KSE_ASSERT_IMPL(a_phase_valid, phase_r, valid_r)

endmodule

// File: src/keyed_span_extractor.sv
// Keyed span extractor: accepts one message byte per cycle while full is low;
// each accepted byte's results pass through the event queue and then the
// output register. A byte with two results gives two output items in turn;
// a four-entry event queue absorbs the burst. Synchronous reset (rst_n low)
// empties the queue and output register and clears all message state.
module keyed_span_extractor
  import kse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_field_kind,
  output logic [15:0] out_span_start,
  output logic [15:0] out_span_length,
  output logic        out_status,
  output logic        out_end_of_run
);

  logic   q_wr;
  logic   q_rd;
  logic   q_empty;
  event_t q_entry;
  event_t q_head;

  kse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .q_full       (full),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_wr         (q_wr),
    .q_entry      (q_entry)
  );

  kse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_entry (q_entry),
    .rd       (q_rd),
    .head     (q_head),
    .empty    (q_empty),
    .full     (full)
  );

  kse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .out_field_kind  (out_field_kind),
    .out_span_start  (out_span_start),
    .out_span_length (out_span_length),
    .out_status      (out_status),
    .out_end_of_run  (out_end_of_run)
  );

endmodule

// File: test/tb.sv
// Testbench for keyed_span_extractor: random and directed byte streams with an
// in-bench span predictor, checked at the result queue. Uses kse_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kse_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 865;
  localparam int QUIET_ITEMS = 150;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        status;
    logic        eor;
  } span_t;

  typedef struct {
    logic [7:0] b;
    logic       lst;
    bit         drain;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_field_kind;
  logic [15:0] out_span_start;
  logic [15:0] out_span_length;
  logic        out_status;
  logic        out_end_of_run;

  keyed_span_extractor u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .empty          (empty),
    .pop            (pop),
    .out_field_kind (out_field_kind),
    .out_span_start (out_span_start),
    .out_span_length(out_span_length),
    .out_status     (out_status),
    .out_end_of_run (out_end_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [55:0] window = '0;
  logic [1:0]  mode = MODE_SCAN;
  logic        arr_asks = 1'b0;
  logic [7:0]  depth = '0;
  logic [15:0] byte_pos = '0;
  logic [15:0] cap = '0;
  logic        halted = 1'b0;

  feed_t      pending[$];
  span_t      span_q[$];
  logic [7:0] msg_buf[$];
  bit         drain_next = 1'b0;

  int items_in = 0;
  int spans_due = 0;
  int spans_seen = 0;
  int errors = 0;
  int msgs = 0;
  int cycles = 0;
  int quiet_from = 32'h7fffffff;
  int long_hold_at = 32'h7fffffff;
  int kind_seen[4] = '{0, 0, 0, 0};

  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic span_t mk_span(input logic [1:0] k, input logic [15:0] s,
                                    input logic [15:0] l, input logic st);
    span_t r;
    r.kind = k;
    r.start = s;
    r.len = l;
    r.status = st;
    r.eor = 1'b0;
    return r;
  endfunction

  task automatic clear_msg_state();
    window = '0;
    mode = MODE_SCAN;
    arr_asks = 1'b0;
    depth = '0;
    byte_pos = '0;
    cap = '0;
    halted = 1'b0;
  endtask

  task automatic extract_spans(input logic [7:0] d, input logic lst, output int n);
    span_t       r[2];
    logic        ended;
    logic        dig;
    logic [15:0] off;
    n = 0;
    ended = 1'b0;
    off = byte_pos;
    dig = (d >= DIGIT_LO) && (d <= DIGIT_HI);
    if (halted) begin
      if (lst) clear_msg_state();
      return;
    end
    if (d == CH_NUL) begin
      ended = 1'b1;
    end else begin
      case (mode)
        MODE_SCAN: begin
          window = {window[47:0], d};
          if (window == KEY_BIDS) begin
            mode = MODE_ARRAY;
            arr_asks = 1'b0;
            depth = '0;
          end else if (window == KEY_ASKS) begin
            mode = MODE_ARRAY;
            arr_asks = 1'b1;
            depth = '0;
          end else if (window == KEY_STAMP) begin
            mode = MODE_SKIP;
          end
        end
        MODE_ARRAY: begin
          if (d == CH_OPEN) begin
            if (depth == 0) cap = off;
            if (depth < DEPTH_MAX) depth = depth + 8'd1;
          end else if (d == CH_CLOSE && depth != 0) begin
            depth = depth - 8'd1;
            if (depth == 0) begin
              r[n] = mk_span(arr_asks ? KIND_ASKS : KIND_BIDS, cap, off - cap + 16'd1, 1'b0);
              n++;
              mode = MODE_SCAN;
            end
          end
        end
        MODE_SKIP: begin
          if (dig) begin
            cap = off;
            mode = MODE_DIGITS;
          end
        end
        default: begin
          if (!dig) begin
            r[n] = mk_span(KIND_STAMP, cap, off - cap, 1'b0);
            n++;
            mode = MODE_SCAN;
          end
        end
      endcase
      if (byte_pos != OFFSET_MAX) byte_pos = byte_pos + 16'd1;
      if (lst) ended = 1'b1;
    end
    if (ended) begin
      if (mode == MODE_DIGITS) begin
        r[n] = mk_span(KIND_STAMP, cap, byte_pos - cap, 1'b0);
        n++;
      end
      r[n] = mk_span(KIND_END, 16'd0, 16'd0, mode == MODE_ARRAY);
      n++;
      clear_msg_state();
      if (!lst) halted = 1'b1;
    end
    if (n > 0) r[n-1].eor = 1'b1;
    for (int i = 0; i < n; i++) span_q.push_back(r[i]);
  endtask

  // Stimulus helpers
  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic put(input logic [7:0] b);
    msg_buf.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic close_msg(input int how);
    feed_t it;
    if (how != 0) put(CH_NUL);
    if (how == 2) repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
    if (msg_buf.size() == 0) put(8'h7b);
    for (int i = 0; i < msg_buf.size(); i++) begin
      it.b = msg_buf[i];
      it.lst = (i == msg_buf.size() - 1);
      it.drain = drain_next && (i == 0);
      pending.push_back(it);
    end
    drain_next = 1'b0;
    msg_buf.delete();
    msgs++;
  endtask

  task automatic put_filler();
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 1) == 0) put(8'($urandom_range(1, 255)));
      else put(pick(",{}: \"abcxyz"));
    end
  endtask

  task automatic put_array(input bit asks);
    int lvl;
    put_text(asks ? "\"asks\":" : "\"bids\":");
    if ($urandom_range(0, 3) == 0) put(CH_CLOSE);
    if ($urandom_range(0, 3) == 0) put(pick(" \""));
    if ($urandom_range(0, 9) == 0) return;
    put(CH_OPEN);
    lvl = 1;
    repeat ($urandom_range(0, 12)) begin
      case ($urandom_range(0, 5))
        0: if (lvl < 5) begin
          put(CH_OPEN);
          lvl++;
        end
        1: if (lvl > 1) begin
          put(CH_CLOSE);
          lvl--;
        end
        default: put(pick(",0123456789.\" "));
      endcase
    end
    if ($urandom_range(0, 11) != 0) begin
      while (lvl > 0) begin
        put(CH_CLOSE);
        lvl--;
      end
    end
  endtask

  task automatic put_stamp();
    put_text("\"timestamp\":");
    repeat ($urandom_range(0, 2)) put(pick(" \""));
    if ($urandom_range(0, 9) == 0) return;
    repeat ($urandom_range(1, 10)) put(8'($urandom_range(DIGIT_LO, DIGIT_HI)));
    if ($urandom_range(0, 5) != 0) put(pick(",}\" x"));
  endtask

  task automatic build_random_msg();
    int r;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
      close_msg(0);
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0, 1:    put_filler();
        2, 3:    put_array(1'b0);
        4, 5:    put_array(1'b1);
        6, 7, 8: put_stamp();
        default: put_text(pick("\"bid\":\"ask\":stamp") == 8'h22 ? "\"bids\"" : "amp\":");
      endcase
    end
    r = $urandom_range(0, 19);
    close_msg(r < 14 ? 0 : (r < 17 ? 1 : 2));
  endtask

  // Driver
  always @(posedge clk) begin : drv
    int  n;
    bit  took;
    bit  go;
    n = 0;
    go = 1'b0;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      took = push && !full;
      if (took) begin
        extract_spans(pending[0].b, pending[0].lst, n);
        void'(pending.pop_front());
        items_in <= items_in + 1;
        spans_due <= spans_due + n;
      end
      if (push && !took) begin
        go = 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending.size() == 0) begin
        go = 1'b0;
      end else if (pending[0].drain && spans_due + n != spans_seen) begin
        go = 1'b0;
      end else if (items_in < quiet_from && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 3);
      end else begin
        go = 1'b1;
        in_data_byte <= pending[0].b;
        in_last_byte <= pending[0].lst;
      end
      push <= go;
    end
  end

  // Result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in >= long_hold_at) begin
      pop <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (items_in < quiet_from && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin : mon
    span_t want;
    span_t got;
    got.kind = out_field_kind;
    got.start = out_span_start;
    got.len = out_span_length;
    got.status = out_status;
    got.eor = out_end_of_run;
    if (rst_n && pop && !empty) begin
      if (span_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d start %0d len %0d status %0d eor %0d",
                   got.kind, got.start, got.len, got.status, got.eor);
      end else begin
        want = span_q.pop_front();
        spans_seen <= spans_seen + 1;
        kind_seen[got.kind]++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d %s",
                     want.kind, want.start, want.len, want.status, want.eor,
                     got.kind, got.start, got.len, got.status, got.eor,
                     "(kind/start/len/status/eor)");
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d spans outstanding", cycles, span_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int base;
    // directed: byte extremes, zero endings, stray close, open array at end,
    // end inside a digit run
    put(8'hff);
    close_msg(0);
    close_msg(1);
    put(8'h80);
    close_msg(2);
    put_text("\"asks\":]");
    close_msg(0);
    put_text("stamp\":9");
    close_msg(0);

    // fill the block while results are held back
    long_hold_at = pending.size();
    repeat (40) begin
      put(8'($urandom_range(1, 255)));
      close_msg(0);
    end
    drain_next = 1'b1;

    // deep nesting
    put_text("\"asks\":");
    repeat (258) put(CH_OPEN);
    repeat (257) put(CH_CLOSE);
    close_msg(0);

    base = pending.size();
    while (pending.size() - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 24) == 0) drain_next = 1'b1;
      build_random_msg();
    end
    quiet_from = pending.size() - QUIET_ITEMS;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 || push) @(posedge clk);
    while (span_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d bytes in %0d messages; spans checked: bids %0d asks %0d stamp %0d end %0d",
             items_in, msgs, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("%0d errors, %0d spans never seen", errors, span_q.size());
    if (errors == 0 && span_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/kse_pkg.sv
src/kse_front.sv
src/kse_queue.sv
src/kse_back.sv
src/keyed_span_extractor.sv
test/tb.sv
